[rtl/mhs_pkg.sv]
// shared types and constants for the murmur2 hash stream unit
package mhs_pkg;

  localparam logic [31:0] MIX_MUL       = 32'h5bd1e995;
  localparam int          WORD_SHIFT    = 24;
  localparam int          FINAL_SHIFT_A = 13;
  localparam int          FINAL_SHIFT_B = 15;
  localparam logic [31:0] SEED_AT_RESET = 32'd5381;

  localparam int          ADDR_W        = 3;
  localparam logic        REG_HASH_SEED = 1'b0;

  localparam logic [2:0]  FULL_BYTES    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KMUL1,
    ST_KMUL2,
    ST_HMIX,
    ST_TAIL,
    ST_FIN1,
    ST_FIN2
  } mhs_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_KMUL1,
    OP_KMUL2,
    OP_HMIX,
    OP_TAIL,
    OP_FIN1,
    OP_FIN2
  } mhs_op_t;

  typedef struct packed {
    mhs_op_t op;
  } mhs_cmd_t;

  typedef struct packed {
    logic in_full;
    logic end_key;
  } mhs_status_t;

endpackage

[rtl/mhs_datapath.sv]
// hash datapath: word capture, shared multiplier, running hash and result register
module mhs_datapath
  import mhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mhs_cmd_t    cmd,
  output mhs_status_t status,
  input  logic [31:0] seed,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_is_last,
  input  logic [31:0] in_total_length,
  output logic [31:0] out_hash_value
);

  logic [31:0] word_r, word_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        last_r, last_nxt;
  logic        inside_r, inside_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] tail_x;
  logic [31:0] mult_a;
  logic [31:0] mult_p;
  logic        count_full;

  assign count_full = (count_r >= FULL_BYTES);

  always_comb begin
    tail_x = h_r;
    if (count_r >= 3'd3) begin
      tail_x = tail_x ^ {8'h00, word_r[23:16], 16'h0000};
    end
    if (count_r >= 3'd2) begin
      tail_x = tail_x ^ {16'h0000, word_r[15:8], 8'h00};
    end
    if (count_r >= 3'd1) begin
      tail_x = tail_x ^ {24'h000000, word_r[7:0]};
    end
  end

  always_comb begin
    case (cmd.op)
      OP_KMUL1: mult_a = word_r;
      OP_KMUL2: mult_a = k_r ^ (k_r >> WORD_SHIFT);
      OP_HMIX:  mult_a = h_r;
      OP_TAIL:  mult_a = tail_x;
      OP_FIN1:  mult_a = h_r ^ (h_r >> FINAL_SHIFT_A);
      default:  mult_a = h_r;
    endcase
  end

  assign mult_p = mult_a * MIX_MUL;

  always_comb begin
    word_nxt   = word_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    inside_nxt = inside_r;
    h_nxt      = h_r;
    k_nxt      = k_r;
    res_nxt    = res_r;
    case (cmd.op)
      OP_LOAD: begin
        word_nxt  = in_data_word;
        count_nxt = in_valid_bytes;
        last_nxt  = in_is_last;
        h_nxt     = inside_r ? h_r : (seed ^ in_total_length);
      end
      OP_KMUL1: k_nxt = mult_p;
      OP_KMUL2: k_nxt = mult_p;
      OP_HMIX: begin
        h_nxt      = mult_p ^ k_r;
        inside_nxt = 1'b1;
      end
      OP_TAIL: h_nxt = (count_r != 3'd0) ? mult_p : tail_x;
      OP_FIN1: h_nxt = mult_p;
      OP_FIN2: begin
        res_nxt    = h_r ^ (h_r >> FINAL_SHIFT_B);
        inside_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
    h_r     <= h_nxt;
    k_r     <= k_nxt;
    res_r   <= res_nxt;
  end

  assign status.in_full = (in_valid_bytes >= FULL_BYTES);
  assign status.end_key = last_r || !count_full;
  assign out_hash_value = res_r;

endmodule

[rtl/mhs_controller.sv]
// sequencing state machine and output valid for the hash datapath
module mhs_controller
  import mhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  mhs_status_t status,
  output mhs_cmd_t    cmd
);

  mhs_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.in_full ? ST_KMUL1 : ST_TAIL;
        end
      end
      ST_KMUL1: state_nxt = ST_KMUL2;
      ST_KMUL2: state_nxt = ST_HMIX;
      ST_HMIX:  state_nxt = status.end_key ? ST_FIN1 : ST_IDLE;
      ST_TAIL:  state_nxt = ST_FIN1;
      ST_FIN1:  state_nxt = ST_FIN2;
      ST_FIN2: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_KMUL1: cmd.op = OP_KMUL1;
      ST_KMUL2: cmd.op = OP_KMUL2;
      ST_HMIX:  cmd.op = OP_HMIX;
      ST_TAIL:  cmd.op = OP_TAIL;
      ST_FIN1:  cmd.op = OP_FIN1;
      ST_FIN2: begin
        if (slot_free) begin
          cmd.op        = OP_FIN2;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/murmur2_hash_stream_unit.sv]
// top level of the streaming 32-bit murmur2 hash unit
//
// key words arrive on the in_ channel (valid/stall), first byte in bits 7:0,
// in_valid_bytes counting valid bytes from the low end; in_total_length is
// read on the first word of each key. a word with fewer than four bytes, or
// with in_is_last set, ends the key. one hash per key leaves on the out_ channel.
// the seed register sits at byte address 0 of the apb port.
// timing: one shared 32x32 multiplier does all mixing, one multiply a cycle.
// a full middle word goes through accept, two key multiplies and the hash multiply.
// a full last word then adds FIN1 and FIN2, and a short last word goes through TAIL,
// FIN1 and FIN2; out_valid rises the cycle after FIN2, when the unit is back in idle for the next word.
// the result register holds the hash while out_stall is high; the next key
// can be loaded and mixed meanwhile, and only the final step waits for the slot.
// reset clears the controller, the in-key flag and out_valid, and loads the
// seed with 5381.
module murmur2_hash_stream_unit
  import mhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_data_word,
  input  logic [2:0]        in_valid_bytes,
  input  logic              in_is_last,
  input  logic [31:0]       in_total_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_hash_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] seed_r, seed_nxt;
  logic        reg_wr;
  mhs_cmd_t    cmd;
  mhs_status_t status;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    seed_nxt = seed_r;
    if (reg_wr && (paddr[2] == REG_HASH_SEED)) begin
      seed_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_AT_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_HASH_SEED) ? seed_r : 32'h0;

  mhs_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mhs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .seed            (seed_r),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_is_last      (in_is_last),
    .in_total_length (in_total_length),
    .out_hash_value  (out_hash_value)
  );

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but unit not busy next cycle");

  a_finish_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN2) |=> out_valid)
    else $error("final step did not raise out_valid");

  a_load_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (in_valid && !in_stall))
    else $error("word loaded without handshake");

endmodule

[dv/murmur2_hash_stream_unit_tb.sv]
// self-checking testbench for the streaming murmur2 hash unit
module murmur2_hash_stream_unit_tb
  import mhs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
    logic [31:0] len;
  } key_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [31:0]       in_data_word = '0;
  logic [2:0]        in_valid_bytes = '0;
  logic              in_is_last = 1'b0;
  logic [31:0]       in_total_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       out_hash_value;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  key_word_t   key_words[$];
  logic [31:0] expected_hashes[$];
  key_word_t   driven_word;
  logic [31:0] seed_model = SEED_AT_RESET;
  logic [31:0] running_hash = '0;
  logic        in_key = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          queued_total = 0;
  int          errors = 0;
  int          quiet_cycles = 0;
  logic [31:0] hash_exp;

  murmur2_hash_stream_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_is_last      (in_is_last),
    .in_total_length (in_total_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash_value  (out_hash_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> FINAL_SHIFT_A);
    x = x * MIX_MUL;
    return x ^ (x >> FINAL_SHIFT_B);
  endfunction

  task automatic absorb_word(input key_word_t w);
    logic [31:0] h;
    logic [31:0] k;
    h = in_key ? running_hash : (seed_model ^ w.len);
    if (w.nbytes >= FULL_BYTES) begin
      k = w.data * MIX_MUL;
      k = k ^ (k >> WORD_SHIFT);
      k = k * MIX_MUL;
      h = (h * MIX_MUL) ^ k;
      if (!w.last) begin
        running_hash = h;
        in_key = 1'b1;
        return;
      end
    end else begin
      if (w.nbytes >= 3) h = h ^ {8'h00, w.data[23:16], 16'h0000};
      if (w.nbytes >= 2) h = h ^ {16'h0000, w.data[15:8], 8'h00};
      if (w.nbytes >= 1) begin
        h = h ^ {24'h000000, w.data[7:0]};
        h = h * MIX_MUL;
      end
    end
    expected_hashes.push_back(avalanche(h));
    running_hash = '0;
    in_key = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic last, input logic [31:0] len);
    key_word_t w;
    w.data = data;
    w.nbytes = nbytes;
    w.last = last;
    w.len = len;
    key_words.push_back(w);
    queued_total++;
  endtask

  task automatic queue_random_key();
    int nwords;
    int tail;
    logic [31:0] len;
    logic last;
    logic [2:0] nb;
    nwords = ($urandom_range(19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
    tail = $urandom_range(0, 4);
    len = (tail == 4) ? 4 * nwords : 4 * (nwords - 1) + tail;
    if ($urandom_range(7) == 0) len = $urandom;
    for (int i = 0; i < nwords; i++) begin
      last = (i == nwords - 1);
      if (last && tail != 4) nb = 3'(tail);
      else nb = ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : FULL_BYTES;
      queue_word($urandom, nb, last, (i == 0) ? len : $urandom);
    end
  endtask

  task automatic queue_random(input int count);
    int start;
    start = queued_total;
    while (queued_total - start < count) begin
      if ($urandom_range(9) == 0) begin
        // noise word with arbitrary fields
        queue_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom), $urandom);
      end else begin
        queue_random_key();
      end
    end
  endtask

  task automatic wait_drained();
    while (key_words.size() != 0 || in_valid || expected_hashes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(REG_HASH_SEED));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    seed_model = value;
    @(negedge clk);
  endtask

  // word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_word(driven_word);
      if (!in_valid || !in_stall) begin
        if (key_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_word = key_words.pop_front();
          in_data_word <= driven_word.data;
          in_valid_bytes <= driven_word.nbytes;
          in_is_last <= driven_word.last;
          in_total_length <= driven_word.len;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // hash monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("unexpected hash_value", out_hash_value, '0);
        end else begin
          hash_exp = expected_hashes.pop_front();
          if (out_hash_value !== hash_exp)
            report_mismatch("hash_value", out_hash_value, hash_exp);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset seed, directed words
    send_idle_pct = 33;
    recv_stall_pct = 62;
    queue_word(32'hffff_ffff, 3'd0, 1'b1, 32'h0000_0000);
    queue_word(32'hffff_ffff, 3'd0, 1'b0, 32'hffff_ffff);
    queue_word(32'hffff_ffff, 3'd1, 1'b1, 32'd1);
    queue_word(32'h0000_0000, 3'd2, 1'b0, 32'd2);
    queue_word(32'hffff_ffff, 3'd3, 1'b1, 32'hffff_ffff);
    queue_word(32'hffff_ffff, FULL_BYTES, 1'b1, 32'd4);
    queue_word(32'h0000_0000, FULL_BYTES, 1'b1, 32'd0);
    queue_word(32'h1234_5678, 3'd7, 1'b1, 32'd4);
    queue_word(32'hffff_ffff, FULL_BYTES, 1'b0, 32'd11);
    queue_word(32'h0000_0000, 3'd5, 1'b0, 32'hffff_ffff);
    queue_word(32'ha5a5_a5a5, 3'd3, 1'b1, 32'hffff_ffff);
    queue_word(32'h5a5a_5a5a, 3'd6, 1'b0, 32'd0);
    queue_word(32'h8000_0001, FULL_BYTES, 1'b0, 32'd0);
    queue_word(32'hffff_ffff, 3'd0, 1'b1, 32'd0);
    queue_word(32'hdead_beef, FULL_BYTES, 1'b0, 32'd8);
    queue_word(32'hcafe_f00d, 3'd2, 1'b0, 32'd0);
    queue_word(32'hffff_ff80, 3'd1, 1'b0, 32'd1);
    queue_word(32'hffff_ffff, FULL_BYTES, 1'b0, 32'd12);
    wait_drained();

    // seed change inside an open key only applies to the next key
    write_seed(32'hffff_ffff);
    queue_word(32'h0123_4567, FULL_BYTES, 1'b0, 32'd0);
    queue_word(32'h89ab_cdef, FULL_BYTES, 1'b1, 32'd0);
    queue_random(300);
    wait_drained();

    send_idle_pct = 62;
    recv_stall_pct = 33;
    write_seed(32'h0000_0000);
    queue_random(300);
    wait_drained();

    write_seed($urandom);
    queue_random(300);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_seed($urandom);
    queue_random(300);
    wait_drained();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
